### src/mhtq_pkg.sv
// Shared widths, codes and types for the min-heap timer queue.
package mhtq_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int ID_SPACE_DEF = 1024;

   localparam int ACT_W  = 3;
   localparam int ID_W   = 10;
   localparam int TMO_W  = 20;
   localparam int KIND_W = 3;
   localparam int IV_W   = 21;
   localparam int EXP_W  = 32;

   // request actions
   localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ADJUST = 3'd1;
   localparam logic [ACT_W-1:0] ACT_DROP   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_TICK   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd4;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_DONE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DROPPED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NEXT    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FULL    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_BADID   = 3'd6;

   localparam logic [IV_W-1:0] IV_MAX  = 21'd1048575;
   localparam logic [IV_W-1:0] IV_NONE = '1;

   // datapath operations
   typedef logic [4:0] op_type;
   localparam op_type OP_NONE    = 5'd0;
   localparam op_type OP_CLEAR   = 5'd1;
   localparam op_type OP_ACCEPT  = 5'd2;
   localparam op_type OP_DECODE  = 5'd3;
   localparam op_type OP_LOOKUP  = 5'd4;
   localparam op_type OP_SD_RD   = 5'd5;
   localparam op_type OP_SD_LAT  = 5'd6;
   localparam op_type OP_SD_PICK = 5'd7;
   localparam op_type OP_SD_CMP  = 5'd8;
   localparam op_type OP_SU_RD   = 5'd9;
   localparam op_type OP_SU_CMP  = 5'd10;
   localparam op_type OP_FINAL   = 5'd11;
   localparam op_type OP_RM      = 5'd12;
   localparam op_type OP_RM_LAT  = 5'd13;
   localparam op_type OP_EXP_RD  = 5'd14;
   localparam op_type OP_EXP_CHK = 5'd15;
   localparam op_type OP_RESP    = 5'd16;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             id_ok;
      logic             slot_valid;
      logic             full;
      logic             j_in;
      logic             j1_in;
      logic             m_lt_c;
      logic             m_lt_rd;
      logic             moved;
      logic             pos_zero;
      logic             rm_tail;
      logic             cnt_zero;
      logic             due;
      logic             clr_done;
   } status_type;

endpackage

### src/min_heap_timer_queue_unit.sv
// Top level of the min-heap timer queue: controller and datapath.
//
// Timers live in a binary min-heap ordered by expiry, with an id-to-slot
// table. After reset the block clears the id table with busy high. An item
// is taken when start is high and busy low; each result beat appears for
// one cycle on rsp_valid and cannot be held off, and the last beat of an
// item carries rsp_last. The heap memory has one read port with registered
// data, so a sift reads each heap level before it compares; a tick or query
// also removes each due timer. busy falls as the last beat is issued.
module min_heap_timer_queue_unit #(
   parameter int CAPACITY = mhtq_pkg::CAPACITY_DEF,
   parameter int ID_SPACE = mhtq_pkg::ID_SPACE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [mhtq_pkg::ACT_W-1:0]        req_action,
   input  logic [mhtq_pkg::ID_W-1:0]         req_timer_id,
   input  logic [mhtq_pkg::TMO_W-1:0]        req_timeout_ticks,
   output logic                              rsp_valid,
   output logic [mhtq_pkg::KIND_W-1:0]       rsp_kind,
   output logic [mhtq_pkg::ID_W-1:0]         rsp_event_id,
   output logic signed [mhtq_pkg::IV_W-1:0]  rsp_interval,
   output logic                              rsp_last
);
   import mhtq_pkg::*;

   status_type status;
   op_type     op;

   mhtq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .op     (op)
   );

   mhtq_datapath #(
      .CAPACITY (CAPACITY),
      .ID_SPACE (ID_SPACE)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .req_action        (req_action),
      .req_timer_id      (req_timer_id),
      .req_timeout_ticks (req_timeout_ticks),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_event_id      (rsp_event_id),
      .rsp_interval      (rsp_interval),
      .rsp_last          (rsp_last)
   );

   // an accepted beat keeps the block busy for at least the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy dropped after accept");

   // an expired beat is never the last one, so more work follows
   a_more_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy) else $error("idle with results pending");

   // the closing response step yields a last beat in the next cycle
   a_resp_beat: assert property (@(posedge clock) disable iff (reset)
      (op == OP_RESP) |=> (rsp_valid && rsp_last)) else $error("final beat missing");

endmodule

### src/mhtq_datapath.sv
// Datapath of the timer queue: heap and id table memories, sift registers, result beat.
module mhtq_datapath #(
   parameter int CAPACITY = mhtq_pkg::CAPACITY_DEF,
   parameter int ID_SPACE = mhtq_pkg::ID_SPACE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mhtq_pkg::op_type              op,
   input  logic [mhtq_pkg::ACT_W-1:0]    req_action,
   input  logic [mhtq_pkg::ID_W-1:0]     req_timer_id,
   input  logic [mhtq_pkg::TMO_W-1:0]    req_timeout_ticks,
   output mhtq_pkg::status_type          status,
   output logic                          rsp_valid,
   output logic [mhtq_pkg::KIND_W-1:0]   rsp_kind,
   output logic [mhtq_pkg::ID_W-1:0]     rsp_event_id,
   output logic signed [mhtq_pkg::IV_W-1:0] rsp_interval,
   output logic                          rsp_last
);
   import mhtq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int JW    = IDX_W + 2;
   localparam int AW    = $clog2(ID_SPACE);
   localparam int ENT_W = ID_W + EXP_W;
   localparam int SL_W  = IDX_W + 1;

   // memories
   logic [ENT_W-1:0] heap_mem [CAPACITY];
   logic [SL_W-1:0]  slot_mem [ID_SPACE];
   logic [ENT_W-1:0] heap_rd_ff;
   logic [SL_W-1:0]  slot_rd_ff;

   // request and sift state
   logic [ACT_W-1:0] act_ff;
   logic [ID_W-1:0]  id_ff;
   logic [TMO_W-1:0] tmo_ff;
   logic [EXP_W-1:0] time_ff, time_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [ID_W-1:0]  m_id_ff, m_id_in, c_id_ff, c_id_in, rem_id_ff, rem_id_in;
   logic [EXP_W-1:0] m_exp_ff, m_exp_in, c_exp_ff, c_exp_in;
   logic [IDX_W-1:0] pos_ff, pos_in, start_ff, start_in, c_idx_ff, c_idx_in;
   logic [CNT_W-1:0] lim_ff, lim_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [IV_W-1:0]  iv_ff, iv_in;

   logic             rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [IV_W-1:0]  rsp_iv_ff, rsp_iv_in;

   // memory port controls
   logic             heap_we, slot_we;
   logic [IDX_W-1:0] heap_wa, heap_ra;
   logic [ENT_W-1:0] heap_wd;
   logic [AW-1:0]    slot_wa, slot_ra;
   logic [SL_W-1:0]  slot_wd;

   logic [ID_W-1:0]  rd_id;
   logic [EXP_W-1:0] rd_exp, diff;
   logic [JW-1:0]    j_w, j1_w;
   logic [IDX_W-1:0] parent, slot_pos;

   assign rd_id    = heap_rd_ff[ENT_W-1:EXP_W];
   assign rd_exp   = heap_rd_ff[EXP_W-1:0];
   assign j_w      = {1'b0, pos_ff, 1'b1};
   assign j1_w     = j_w + JW'(1);
   assign parent   = (pos_ff - IDX_W'(1)) >> 1;
   assign slot_pos = slot_rd_ff[IDX_W-1:0];
   assign slot_ra  = AW'(id_ff);
   assign diff     = rd_exp - time_ff;

   // status towards the controller
   assign status.act        = act_ff;
   assign status.id_ok      = (id_ff != '0) && (32'(id_ff) < 32'(ID_SPACE));
   assign status.slot_valid = slot_rd_ff[IDX_W];
   assign status.full       = cnt_ff == CNT_W'(CAPACITY);
   assign status.j_in       = j_w < JW'(lim_ff);
   assign status.j1_in      = j1_w < JW'(lim_ff);
   assign status.m_lt_c     = m_exp_ff < c_exp_ff;
   assign status.m_lt_rd    = m_exp_ff < rd_exp;
   assign status.moved      = pos_ff > start_ff;
   assign status.pos_zero   = pos_ff == '0;
   assign status.rm_tail    = CNT_W'(pos_ff) == cnt_ff - CNT_W'(1);
   assign status.cnt_zero   = cnt_ff == '0;
   assign status.due        = rd_exp <= time_ff;
   assign status.clr_done   = clr_ff == AW'(ID_SPACE - 1);

   // work out next state and memory accesses for the current operation
   always_comb begin
      time_in = time_ff;   cnt_in = cnt_ff;     clr_in = clr_ff;
      m_id_in = m_id_ff;   m_exp_in = m_exp_ff; c_id_in = c_id_ff;
      c_exp_in = c_exp_ff; c_idx_in = c_idx_ff; rem_id_in = rem_id_ff;
      pos_in = pos_ff;     start_in = start_ff; lim_in = lim_ff;
      kind_in = kind_ff;   iv_in = iv_ff;
      rsp_valid_in = 1'b0; rsp_kind_in = rsp_kind_ff; rsp_id_in = rsp_id_ff;
      rsp_iv_in = rsp_iv_ff; rsp_last_in = rsp_last_ff;
      heap_we = 1'b0; heap_wa = pos_ff; heap_wd = {m_id_ff, m_exp_ff};
      heap_ra = '0;
      slot_we = 1'b0; slot_wa = AW'(m_id_ff); slot_wd = {1'b1, pos_ff};
      case (op)
         OP_CLEAR: begin
            slot_we = 1'b1; slot_wa = clr_ff; slot_wd = '0;
            clr_in  = clr_ff + AW'(1);
         end
         OP_DECODE: begin
            if (act_ff == ACT_TICK) time_in = time_ff + EXP_W'(1);
            if (act_ff == ACT_QUERY) kind_in = KIND_NEXT;
            else if (act_ff <= ACT_DROP && !status.id_ok) kind_in = KIND_BADID;
            else kind_in = KIND_DONE;
         end
         OP_LOOKUP: begin
            m_id_in  = id_ff;
            m_exp_in = time_ff + EXP_W'(tmo_ff);
            if (act_ff == ACT_DROP) begin
               rem_id_in = id_ff;
               pos_in    = slot_pos;
               kind_in   = status.slot_valid ? KIND_DROPPED : KIND_UNKNOWN;
            end else if (status.slot_valid) begin
               pos_in = slot_pos; start_in = slot_pos; lim_in = cnt_ff;
            end else if (act_ff == ACT_ADJUST) begin
               kind_in = KIND_UNKNOWN;
            end else if (status.full) begin
               kind_in = KIND_FULL;
            end else begin
               pos_in   = IDX_W'(cnt_ff);
               start_in = IDX_W'(cnt_ff);
               cnt_in   = cnt_ff + CNT_W'(1);
               lim_in   = cnt_ff + CNT_W'(1);
            end
         end
         OP_SD_RD: heap_ra = j_w[IDX_W-1:0];
         OP_SD_LAT: begin
            c_id_in = rd_id; c_exp_in = rd_exp; c_idx_in = j_w[IDX_W-1:0];
            heap_ra = j1_w[IDX_W-1:0];
         end
         OP_SD_PICK: begin
            if (rd_exp < c_exp_ff) begin
               c_id_in = rd_id; c_exp_in = rd_exp; c_idx_in = j1_w[IDX_W-1:0];
            end
         end
         OP_SD_CMP: begin
            // pull the chosen child up into the hole
            if (!status.m_lt_c) begin
               heap_we = 1'b1; heap_wd = {c_id_ff, c_exp_ff};
               slot_we = 1'b1; slot_wa = AW'(c_id_ff);
               pos_in  = c_idx_ff;
            end
         end
         OP_SU_RD: heap_ra = parent;
         OP_SU_CMP: begin
            // push the parent down into the hole
            if (status.m_lt_rd) begin
               heap_we = 1'b1; heap_wd = heap_rd_ff;
               slot_we = 1'b1; slot_wa = AW'(rd_id);
               pos_in  = parent;
            end
         end
         OP_FINAL: begin
            heap_we = 1'b1;
            slot_we = 1'b1;
         end
         OP_RM: begin
            slot_we = 1'b1; slot_wa = AW'(rem_id_ff); slot_wd = '0;
            heap_ra = IDX_W'(cnt_ff - CNT_W'(1));
            cnt_in  = cnt_ff - CNT_W'(1);
         end
         OP_RM_LAT: begin
            m_id_in = rd_id; m_exp_in = rd_exp;
            start_in = pos_ff; lim_in = cnt_ff;
         end
         OP_EXP_RD: heap_ra = '0;
         OP_EXP_CHK: begin
            if (!status.cnt_zero && status.due) begin
               rsp_valid_in = 1'b1; rsp_kind_in = KIND_EXPIRED; rsp_id_in = rd_id;
               rsp_iv_in = '0; rsp_last_in = 1'b0;
               rem_id_in = rd_id; pos_in = '0;
            end else if (status.cnt_zero) begin
               iv_in = IV_NONE;
            end else if (diff > EXP_W'(IV_MAX)) begin
               iv_in = IV_MAX;
            end else begin
               iv_in = diff[IV_W-1:0];
            end
         end
         OP_RESP: begin
            rsp_valid_in = 1'b1; rsp_kind_in = kind_ff; rsp_last_in = 1'b1;
            rsp_id_in = (kind_ff == KIND_DROPPED) ? id_ff : '0;
            rsp_iv_in = (kind_ff == KIND_NEXT) ? iv_ff : '0;
         end
         default: ;
      endcase
   end

   // memories with registered read data
   always_ff @(posedge clock) begin
      if (heap_we) heap_mem[heap_wa] <= heap_wd;
      heap_rd_ff <= heap_mem[heap_ra];
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      slot_rd_ff <= slot_mem[slot_ra];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0; cnt_ff <= '0; clr_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         time_ff <= time_in; cnt_ff <= cnt_in; clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (op == OP_ACCEPT) begin
         act_ff <= req_action; id_ff <= req_timer_id; tmo_ff <= req_timeout_ticks;
      end
      m_id_ff <= m_id_in;   m_exp_ff <= m_exp_in; c_id_ff <= c_id_in;
      c_exp_ff <= c_exp_in; c_idx_ff <= c_idx_in; rem_id_ff <= rem_id_in;
      pos_ff <= pos_in;     start_ff <= start_in; lim_ff <= lim_in;
      kind_ff <= kind_in;   iv_ff <= iv_in;
      rsp_kind_ff <= rsp_kind_in; rsp_id_ff <= rsp_id_in;
      rsp_iv_ff <= rsp_iv_in;     rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_event_id = rsp_id_ff;
   assign rsp_interval = rsp_iv_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

### src/mhtq_ctrl.sv
// Controller state machine of the timer queue: sequences lookups, sifts and removals.
module mhtq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  mhtq_pkg::status_type status,
   output mhtq_pkg::op_type     op
);
   import mhtq_pkg::*;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DECODE  = 4'd2;
   localparam logic [3:0] S_LOOKUP  = 4'd3;
   localparam logic [3:0] S_SD_RD   = 4'd4;
   localparam logic [3:0] S_SD_LAT  = 4'd5;
   localparam logic [3:0] S_SD_PICK = 4'd6;
   localparam logic [3:0] S_SD_CMP  = 4'd7;
   localparam logic [3:0] S_SU_RD   = 4'd8;
   localparam logic [3:0] S_SU_CMP  = 4'd9;
   localparam logic [3:0] S_FINAL   = 4'd10;
   localparam logic [3:0] S_RM      = 4'd11;
   localparam logic [3:0] S_RM_LAT  = 4'd12;
   localparam logic [3:0] S_EXP_RD  = 4'd13;
   localparam logic [3:0] S_EXP_CHK = 4'd14;
   localparam logic [3:0] S_RESP    = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [3:0] after_op, after_down;

   // where to go once a heap update is finished
   assign after_op   = (status.act == ACT_TICK || status.act == ACT_QUERY) ? S_EXP_RD : S_RESP;
   assign after_down = status.moved ? S_FINAL : S_SU_RD;
   assign busy       = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      case (state_ff)
         S_CLEAR: begin
            op = OP_CLEAR;
            if (status.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               op = OP_ACCEPT; state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            op = OP_DECODE;
            if (status.act inside {ACT_ADD, ACT_ADJUST, ACT_DROP})
               state_in = status.id_ok ? S_LOOKUP : S_RESP;
            else if (status.act inside {ACT_TICK, ACT_QUERY})
               state_in = S_EXP_RD;
            else
               state_in = S_RESP;
         end
         S_LOOKUP: begin
            op = OP_LOOKUP;
            if (status.act == ACT_DROP)
               state_in = status.slot_valid ? S_RM : S_RESP;
            else if (status.slot_valid)
               state_in = S_SD_RD;
            else if (status.act == ACT_ADD && !status.full)
               state_in = S_SD_RD;
            else
               state_in = S_RESP;
         end
         S_SD_RD: begin
            op = OP_SD_RD;
            state_in = status.j_in ? S_SD_LAT : after_down;
         end
         S_SD_LAT: begin
            op = OP_SD_LAT;
            state_in = status.j1_in ? S_SD_PICK : S_SD_CMP;
         end
         S_SD_PICK: begin
            op = OP_SD_PICK; state_in = S_SD_CMP;
         end
         S_SD_CMP: begin
            op = OP_SD_CMP;
            state_in = status.m_lt_c ? after_down : S_SD_RD;
         end
         S_SU_RD: begin
            op = OP_SU_RD;
            state_in = status.pos_zero ? S_FINAL : S_SU_CMP;
         end
         S_SU_CMP: begin
            op = OP_SU_CMP;
            state_in = status.m_lt_rd ? S_SU_RD : S_FINAL;
         end
         S_FINAL: begin
            op = OP_FINAL; state_in = after_op;
         end
         S_RM: begin
            op = OP_RM;
            state_in = status.rm_tail ? after_op : S_RM_LAT;
         end
         S_RM_LAT: begin
            op = OP_RM_LAT; state_in = S_SD_RD;
         end
         S_EXP_RD: begin
            op = OP_EXP_RD; state_in = S_EXP_CHK;
         end
         S_EXP_CHK: begin
            op = OP_EXP_CHK;
            state_in = (!status.cnt_zero && status.due) ? S_RM : S_RESP;
         end
         S_RESP: begin
            op = OP_RESP; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule
